// File: rtl/rbd_pkg.sv
// ---------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the ray/box border distance unit.
// ---------------------------------------------------------------------------
package rbd_pkg;

  // Fixed field widths.
  localparam int COORD_W   = 32;
  localparam int LEN_W     = 31;
  localparam int PREC_W    = 16;
  localparam int T_W       = 31;
  // Face numerators carry one extra fraction bit and the sum growth.
  localparam int NUM_W     = 35;
  // Quotient shift between the doubled Q16.16 numerator and the Q1.30 direction.
  localparam int QSHIFT    = 29;
  localparam int PROD_W    = 64;
  localparam int DIV_STEPS = T_W;
  localparam int FACES     = 6;

  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_LENGTH_X  = 3'd3,
    REG_LENGTH_Y  = 3'd4,
    REG_LENGTH_Z  = 3'd5,
    REG_PRECISION = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  // Box configuration as seen by the datapath.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] center;
    logic [2:0][LEN_W-1:0]   length;
    logic [PREC_W-1:0]       prec;
  } cfg_t;

  // One classified ray: face numerators per axis and the direction.
  typedef struct packed {
    logic [2:0][NUM_W-1:0]   dlo;
    logic [2:0][NUM_W-1:0]   dhi;
    logic [2:0][COORD_W-1:0] dir;
  } q_item_t;

  // State of one face lane in the divider pipeline.
  typedef struct packed {
    logic             pos;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [31:0]      ud;
    logic [T_W-1:0]   q;
  } div_t;

endpackage

// File: rtl/ray_box_border_distance_unit.sv
// ---------------------------------------------------------------------------
// ray_box_border_distance_unit
// Border distances of a ray against a configurable axis-aligned box.
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | contents
//  in_     | input     | valid / stall    | ray origin and direction
//  out_    | output    | valid / stall    | near/far distances, bad count flag
//  cfg_    | input     | valid / ready    | register index and write data
//
// One ray is taken every cycle while in_stall is low. An accepted request
// passes the queue, then 31 quotient stages run side by side for the six
// faces, then bound products, bound check and hit combination.
// Reset is synchronous and clears the queue and the valid chain, and returns
// the configuration registers to their reset values. An output stall freezes
// the back; the two-entry queue keeps taking requests until it is full, then
// in_stall rises.
// ---------------------------------------------------------------------------
module ray_box_border_distance_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_origin_y,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_origin_z,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_dir_x,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_dir_y,
  input  logic signed [rbd_pkg::COORD_W-1:0] in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rbd_pkg::T_W-1:0]           out_near_dist,
  output logic                              out_near_valid,
  output logic [rbd_pkg::T_W-1:0]           out_far_dist,
  output logic                              out_far_valid,
  output logic                              out_bad_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);
  import rbd_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_item_t front_item, head;
  logic    q_full, q_valid, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:  cfg_nxt.center[0] = cfg_data;
        REG_CENTER_Y:  cfg_nxt.center[1] = cfg_data;
        REG_CENTER_Z:  cfg_nxt.center[2] = cfg_data;
        REG_LENGTH_X:  cfg_nxt.length[0] = cfg_data[LEN_W-1:0];
        REG_LENGTH_Y:  cfg_nxt.length[1] = cfg_data[LEN_W-1:0];
        REG_LENGTH_Z:  cfg_nxt.length[2] = cfg_data[LEN_W-1:0];
        REG_PRECISION: cfg_nxt.prec      = cfg_data[PREC_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= '0;
      cfg_r.length <= {3{LEN_W'(65536)}};
      cfg_r.prec   <= PREC_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbd_front u_front (
    .cfg_i    (cfg_r),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .item_o   (front_item)
  );

  rbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  rbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .q_valid        (q_valid),
    .q_item         (head),
    .q_pop          (q_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_near_dist  (out_near_dist),
    .out_near_valid (out_near_valid),
    .out_far_dist   (out_far_dist),
    .out_far_valid  (out_far_valid),
    .out_bad_count  (out_bad_count)
  );

  // A far distance never stands without a near one, and is the larger.
  a_far_needs_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_far_valid |-> out_near_valid && (out_far_dist > out_near_dist))
    else $error("far distance without a smaller near distance");

  // A bad count carries no distance.
  a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_count |-> !out_near_valid && !out_far_valid)
    else $error("bad count with a distance present");

  // A full queue that is not drained stays full and keeps the input stalled.
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !q_pop |=> in_stall)
    else $error("queue lost an entry without a pop");

endmodule

// File: rtl/rbd_front.sv
// ---------------------------------------------------------------------------
// rbd_front
// Forms the doubled-scale face plane offsets of a ray against the box.
// ---------------------------------------------------------------------------
module rbd_front (
  input  rbd_pkg::cfg_t                      cfg_i,
  input  logic signed [rbd_pkg::COORD_W-1:0] origin_x,
  input  logic signed [rbd_pkg::COORD_W-1:0] origin_y,
  input  logic signed [rbd_pkg::COORD_W-1:0] origin_z,
  input  logic signed [rbd_pkg::COORD_W-1:0] dir_x,
  input  logic signed [rbd_pkg::COORD_W-1:0] dir_y,
  input  logic signed [rbd_pkg::COORD_W-1:0] dir_z,
  output rbd_pkg::q_item_t                   item_o
);
  import rbd_pkg::*;

  logic [2:0][COORD_W-1:0] org;

  assign org = {origin_z, origin_y, origin_x};

  // Plane offsets: (2*center -/+ length) - 2*origin, exact in NUM_W bits.
  always_comb begin
    logic [NUM_W-1:0] c2, o2, len;
    item_o.dir = {dir_z, dir_y, dir_x};
    for (int a = 0; a < 3; a++) begin
      c2  = {{2{cfg_i.center[a][COORD_W-1]}}, cfg_i.center[a], 1'b0};
      o2  = {{2{org[a][COORD_W-1]}}, org[a], 1'b0};
      len = {{(NUM_W-LEN_W){1'b0}}, cfg_i.length[a]};
      item_o.dlo[a] = c2 - len - o2;
      item_o.dhi[a] = c2 + len - o2;
    end
  end

endmodule

// File: rtl/rbd_queue.sv
// ---------------------------------------------------------------------------
// rbd_queue
// Two-entry request queue between the front and the back.
// ---------------------------------------------------------------------------
module rbd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rbd_pkg::q_item_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output rbd_pkg::q_item_t head
);
  import rbd_pkg::*;

  q_item_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/rbd_back.sv
// ---------------------------------------------------------------------------
// rbd_back
// Pipelined face divides, face bound checks and hit combination.
// ---------------------------------------------------------------------------
module rbd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbd_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid,
  input  rbd_pkg::q_item_t              q_item,
  output logic                          q_pop,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [rbd_pkg::T_W-1:0]       out_near_dist,
  output logic                          out_near_valid,
  output logic [rbd_pkg::T_W-1:0]       out_far_dist,
  output logic                          out_far_valid,
  output logic                          out_bad_count
);
  import rbd_pkg::*;

  // One restoring division step; the first two steps give the integer bits.
  function automatic div_t div_step(input div_t x, input int k);
    logic [NUM_W:0] r, dd;
    div_t y;
    y = x;
    if (k == 0) begin
      r  = {1'b0, x.rem};
      dd = {3'b000, x.ud, 1'b0};
    end else if (k == 1) begin
      r  = {1'b0, x.rem};
      dd = {4'b0000, x.ud};
    end else begin
      r  = {x.rem, 1'b0};
      dd = {4'b0000, x.ud};
    end
    if (r >= dd) begin
      r   = r - dd;
      y.q = {x.q[T_W-2:0], 1'b1};
    end else begin
      y.q = {x.q[T_W-2:0], 1'b0};
    end
    y.rem = r[NUM_W-1:0];
    return y;
  endfunction

  logic adv;

  logic [DIV_STEPS:0] v_r;
  div_t               lane_r [DIV_STEPS+1][FACES];
  q_item_t            side_r [DIV_STEPS+1];
  div_t               entry  [FACES];

  logic                     vm_r;
  logic [T_W-1:0]           tm_r   [FACES];
  logic                     posm_r [FACES];
  logic signed [PROD_W-1:0] td_r   [FACES][2];
  q_item_t                  sidem_r;

  logic           vk_r;
  logic [FACES-1:0] keep_r, keep_nxt;
  logic [T_W-1:0] tk_r [FACES];

  logic           out_valid_r;
  logic [T_W-1:0] near_r, near_nxt, far_r, far_nxt;
  logic           nv_r, nv_nxt, fv_r, fv_nxt, bad_r, bad_nxt;

  // The whole back advances whenever the output register can take a result.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  // Lane entry: sign test, magnitudes and saturation check per face.
  always_comb begin
    logic [NUM_W-1:0]   num, un;
    logic [COORD_W-1:0] dv;
    logic [31:0]        ud;
    for (int f = 0; f < FACES; f++) begin
      num = (f % 2 == 0) ? q_item.dhi[f/2] : q_item.dlo[f/2];
      dv  = q_item.dir[f/2];
      un  = num[NUM_W-1] ? (~num + 1'b1) : num;
      ud  = dv[COORD_W-1] ? (~dv + 1'b1) : dv;
      entry[f].pos = (num != '0) && (dv != '0) && (num[NUM_W-1] == dv[COORD_W-1]);
      entry[f].sat = un >= {1'b0, ud, 2'b00};
      entry[f].rem = un;
      entry[f].ud  = ud;
      entry[f].q   = '0;
    end
  end

  // Valid chain, reset as control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      vm_r        <= 1'b0;
      vk_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[DIV_STEPS-1:0], q_valid};
      vm_r        <= v_r[DIV_STEPS];
      vk_r        <= vm_r;
      out_valid_r <= vk_r;
    end
  end

  // Divider pipeline, one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= q_item;
      for (int f = 0; f < FACES; f++) begin
        lane_r[0][f] <= entry[f];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
        side_r[s+1] <= side_r[s];
        for (int f = 0; f < FACES; f++) begin
          lane_r[s+1][f] <= div_step(lane_r[s][f], s);
        end
      end
    end
  end

  // Distance and the point reached on the two other axes.
  always_ff @(posedge clk) begin
    logic [T_W-1:0]     t;
    logic signed [32:0] ts;
    logic signed [31:0] db, de;
    if (adv) begin
      sidem_r <= side_r[DIV_STEPS];
      for (int f = 0; f < FACES; f++) begin
        t  = lane_r[DIV_STEPS][f].sat ? T_MAX : lane_r[DIV_STEPS][f].q;
        ts = $signed({2'b00, t});
        db = $signed(side_r[DIV_STEPS].dir[(f/2 + 1) % 3]);
        de = $signed(side_r[DIV_STEPS].dir[(f/2 + 2) % 3]);
        tm_r[f]     <= t;
        posm_r[f]   <= lane_r[DIV_STEPS][f].pos;
        td_r[f][0]  <= ts * db;
        td_r[f][1]  <= ts * de;
      end
    end
  end

  // Forward hits inside the face bounds and at or above the precision limit.
  always_comb begin
    logic signed [PROD_W-1:0] lo, hi;
    logic                     ok;
    int                       b;
    for (int f = 0; f < FACES; f++) begin
      ok = posm_r[f] && (tm_r[f] != '0) &&
           (tm_r[f] >= {{(T_W-PREC_W){1'b0}}, cfg_i.prec});
      for (int j = 0; j < 2; j++) begin
        b  = (f/2 + 1 + j) % 3;
        lo = $signed({sidem_r.dlo[b], {QSHIFT{1'b0}}});
        hi = $signed({sidem_r.dhi[b], {QSHIFT{1'b0}}});
        ok = ok && (lo <= td_r[f][j]) && (td_r[f][j] <= hi);
      end
      keep_nxt[f] = ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      keep_r <= keep_nxt;
      for (int f = 0; f < FACES; f++) begin
        tk_r[f] <= tm_r[f];
      end
    end
  end

  // Combine the kept hits into near and far distances.
  always_comb begin
    logic [T_W-1:0] h0, h1, h2;
    logic [2:0]     n;
    h0 = '0;
    h1 = '0;
    h2 = '0;
    n  = '0;
    for (int f = 0; f < FACES; f++) begin
      if (keep_r[f]) begin
        if (n == 3'd0) begin
          h0 = tk_r[f];
        end else if (n == 3'd1) begin
          h1 = tk_r[f];
        end else if (n == 3'd2) begin
          h2 = tk_r[f];
        end
        n = n + 3'd1;
      end
    end
    near_nxt = '0;
    far_nxt  = '0;
    nv_nxt   = 1'b0;
    fv_nxt   = 1'b0;
    bad_nxt  = 1'b0;
    if (n == 3'd1) begin
      near_nxt = h0;
      nv_nxt   = 1'b1;
    end else if (n == 3'd2) begin
      nv_nxt = 1'b1;
      if (h0 == h1) begin
        near_nxt = h0;
      end else begin
        near_nxt = (h0 < h1) ? h0 : h1;
        far_nxt  = (h0 < h1) ? h1 : h0;
        fv_nxt   = 1'b1;
      end
    end else if (n == 3'd3 && h0 == h1 && h1 == h2) begin
      near_nxt = h0;
      nv_nxt   = 1'b1;
    end else if (n != 3'd0) begin
      bad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
      nv_r   <= nv_nxt;
      fv_r   <= fv_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_near_dist  = near_r;
  assign out_near_valid = nv_r;
  assign out_far_dist   = far_r;
  assign out_far_valid  = fv_r;
  assign out_bad_count  = bad_r;

endmodule

// File: test/ray_box_border_distance_unit_test.sv
// ---------------------------------------------------------------------------
// ray_box_border_distance_unit_test
// Self-checking bench for the ray/box border distance unit. Rays are sent
// under random idling on both channels and every result is compared with a
// distance predictor kept in the bench, across several box settings.
// ---------------------------------------------------------------------------
module ray_box_border_distance_unit_test;
  import rbd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 200;

  typedef struct {
    logic [T_W-1:0] near_dist;
    logic           near_valid;
    logic [T_W-1:0] far_dist;
    logic           far_valid;
    logic           bad_count;
  } border_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [COORD_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [T_W-1:0] out_near_dist, out_far_dist;
  logic out_near_valid, out_far_valid, out_bad_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the box registers.
  longint box_center [3];
  longint box_length [3];
  longint prec_limit;

  border_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  ray_box_border_distance_unit dut (.*);

  always #5 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ray_box_border_distance_unit verification failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: compares each accepted request result with the oldest one.
  always @(posedge clk) begin
    border_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result near=%0h far=%0h", out_near_dist, out_far_dist);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_near_dist !== exp_r.near_dist) begin
          $error("near_dist exp %0h got %0h", exp_r.near_dist, out_near_dist); errors++;
        end
        if (out_near_valid !== exp_r.near_valid) begin
          $error("near_valid exp %0b got %0b", exp_r.near_valid, out_near_valid); errors++;
        end
        if (out_far_dist !== exp_r.far_dist) begin
          $error("far_dist exp %0h got %0h", exp_r.far_dist, out_far_dist); errors++;
        end
        if (out_far_valid !== exp_r.far_valid) begin
          $error("far_valid exp %0b got %0b", exp_r.far_valid, out_far_valid); errors++;
        end
        if (out_bad_count !== exp_r.bad_count) begin
          $error("bad_count exp %0b got %0b", exp_r.bad_count, out_bad_count); errors++;
        end
      end
    end
  end

  // Plane crossing parameter as a saturated Q15.16 magnitude; 0 when not forward.
  function automatic longint unsigned crossing_t(longint num, longint d);
    longint unsigned un, ud;
    if (num == 0 || d == 0 || ((num < 0) != (d < 0))) return 0;
    un = (num < 0) ? -num : num;
    ud = (d < 0) ? -d : d;
    if (un >= (ud << 2)) return 64'h7FFF_FFFF;
    return (un << QSHIFT) / ud;
  endfunction

  function automatic longint clamp33(longint v);
    if (v > (64'sd1 <<< 33)) return 64'sd1 <<< 33;
    if (v < -(64'sd1 <<< 33)) return -(64'sd1 <<< 33);
    return v;
  endfunction

  // Does the point at t stay within the face bounds on this axis?
  function automatic bit on_face(longint o2, longint d, longint unsigned t,
                                 longint lo2, longint hi2);
    longint td, lo, hi;
    td = longint'(t) * d;
    lo = clamp33(lo2 - o2) * (64'sd1 <<< QSHIFT);
    hi = clamp33(hi2 - o2) * (64'sd1 <<< QSHIFT);
    return lo <= td && td <= hi;
  endfunction

  function automatic border_t predict_border(logic signed [COORD_W-1:0] org [3],
                                            logic signed [COORD_W-1:0] dir [3]);
    longint o2 [3], d [3], lo2 [3], hi2 [3];
    longint unsigned hits [6];
    longint unsigned t, first, second, plane;
    int n, b, e;
    bit fv, sv, bad;
    border_t r;
    n = 0; first = 0; second = 0; fv = 0; sv = 0; bad = 0;
    for (int a = 0; a < 3; a++) begin
      o2[a] = 2 * longint'(org[a]);
      d[a] = longint'(dir[a]);
      lo2[a] = 2 * box_center[a] - box_length[a];
      hi2[a] = 2 * box_center[a] + box_length[a];
    end
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) continue;
      for (int s = 0; s < 2; s++) begin
        plane = (s == 0) ? hi2[a] : lo2[a];
        t = crossing_t(longint'(plane) - o2[a], d[a]);
        b = (a + 1) % 3;
        e = (a + 2) % 3;
        if (t == 0 || t < prec_limit) continue;
        if (on_face(o2[b], d[b], t, lo2[b], hi2[b]) && on_face(o2[e], d[e], t, lo2[e], hi2[e])) begin
          hits[n] = t;
          n++;
        end
      end
    end
    if (n == 1) begin
      first = hits[0]; fv = 1;
    end else if (n == 2) begin
      if (hits[0] == hits[1]) begin
        first = hits[0]; fv = 1;
      end else begin
        first = (hits[0] < hits[1]) ? hits[0] : hits[1];
        second = (hits[0] < hits[1]) ? hits[1] : hits[0];
        fv = 1; sv = 1;
      end
    end else if (n == 3 && hits[0] == hits[1] && hits[1] == hits[2]) begin
      first = hits[0]; fv = 1;
    end else if (n != 0) begin
      bad = 1;
    end
    if (fv && first < prec_limit) begin fv = 0; first = 0; end
    if (sv && second < prec_limit) begin sv = 0; second = 0; end
    if (!fv && sv) begin first = second; fv = 1; second = 0; sv = 0; end
    r.near_dist = fv ? first[T_W-1:0] : '0;
    r.near_valid = fv;
    r.far_dist = sv ? second[T_W-1:0] : '0;
    r.far_valid = sv;
    r.bad_count = bad;
    return r;
  endfunction

  // Sends one ray request and records its expected distances on acceptance.
  task automatic send_ray(logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz);
    logic signed [COORD_W-1:0] org [3];
    logic signed [COORD_W-1:0] dir [3];
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_border(org, dir)};
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected result, then lets the pipeline settle.
  task automatic drain();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z:
        box_center[idx] = longint'($signed(value));
      REG_LENGTH_X, REG_LENGTH_Y, REG_LENGTH_Z:
        box_length[idx - REG_LENGTH_X] = longint'(value[LEN_W-1:0]);
      REG_PRECISION: prec_limit = value[PREC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_box(logic [31:0] cx, cy, cz, lx, ly, lz, pl);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_LENGTH_X, lx);
    write_reg(REG_LENGTH_Y, ly);
    write_reg(REG_LENGTH_Z, lz);
    write_reg(REG_PRECISION, pl);
    write_reg(REG_UNUSED, $urandom);
  endtask

  // A direction component: mostly unit scale, sometimes zero or extreme.
  function automatic logic [31:0] rand_dir();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  // An origin coordinate near the box on this axis, or anywhere.
  function automatic logic [31:0] rand_origin(int a);
    longint span;
    if ($urandom_range(9) == 0) return $urandom;
    span = box_length[a] * 2 + 64;
    return 32'(box_center[a] + longint'($urandom_range(32'(span > 32'h7FFF_FFFF ?
           32'h7FFF_FFFF : span))) - span / 2);
  endfunction

  task automatic send_random_ray();
    send_ray(rand_origin(0), rand_origin(1), rand_origin(2), rand_dir(), rand_dir(), rand_dir());
  endtask

  // Directed rays: axis hits, corners, zero direction, extremes, saturation.
  task automatic test_directed();
    send_ray(0, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(0, 0, 0, 32'hC000_0000, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'hFFFE_0000, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(32'h0002_0000, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
             32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
    send_ray(0, 0, 0, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
    send_ray(0, 0, 0, 32'h4000_0000, 32'h4000_0000, 0);
    send_ray(32'h8000_0000, 0, 0, 1, 0, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h0000_7FFF, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(0, 32'hFFFF_0000, 0, 0, 32'h0000_0001, 0);
    send_ray(0, 32'h0000_8000, 0, 0, 32'h4000_0000, 0);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ray(0, 0, 32'hFFFF_8000, 32'h0000_0001, 32'h0000_0001, 32'h4000_0000);
    drain();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) send_random_ray();
    drain();
  endtask

  // Receiver holds off long enough for the queue to fill and stall the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 80; i++) send_random_ray();
    drain();
  endtask

  initial begin
    box_center = '{0, 0, 0};
    box_length = '{65536, 65536, 65536};
    prec_limit = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_box(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0000_0100);
    test_directed();
    test_random(150, 32, 72);
    set_box(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
            32'h0004_0000, 32'h0001_0000, 32'h0008_0000, 0);
    test_random(150, 72, 32);
    set_box(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h0000_FFFF);
    test_random(120, 0, 0);
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    test_random(120, 32, 72);
    set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(100, 72, 32);
    set_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
    test_backpressure();
    test_random(330, 0, 0);

    if (errors == 0) begin
      $display("ray_box_border_distance_unit verification clean");
    end else begin
      $display("ray_box_border_distance_unit verification failed");
    end
    $finish;
  end

endmodule
